[design/sha_pkg.sv]
`timescale 1ns / 1ps
package sha_pkg;

  localparam int WordW = 64;
  localparam int Rounds = 80;
  localparam int BlockWords = 16;
  localparam int LenWord = 15;
  localparam logic [WordW-1:0] PadWord = 64'h8000000000000000;

  typedef logic [WordW-1:0] word_t;

  function automatic word_t round_const(input logic [6:0] t);
    word_t k;
    begin
      unique case (t)
        7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
        7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
        7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
        7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
        7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
        7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
        7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
        7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
        7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
        7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
        7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
        7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
        7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
        7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
        7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
        7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
        7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
        7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
        7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
        7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
        7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
        7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
        7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
        7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
        7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
        7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
        7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
        7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
        7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
        7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
        7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
        7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
        7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
        7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
        7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
        7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
        7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
        7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
        7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
        7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
        default: k = '0;
      endcase
      return k;
    end
  endfunction

  function automatic word_t init_value(input logic v384, input logic [2:0] i);
    word_t h;
    begin
      unique case ({v384, i})
        4'd0: h = 64'h6a09e667f3bcc908;  4'd1: h = 64'hbb67ae8584caa73b;
        4'd2: h = 64'h3c6ef372fe94f82b;  4'd3: h = 64'ha54ff53a5f1d36f1;
        4'd4: h = 64'h510e527fade682d1;  4'd5: h = 64'h9b05688c2b3e6c1f;
        4'd6: h = 64'h1f83d9abfb41bd6b;  4'd7: h = 64'h5be0cd19137e2179;
        4'd8: h = 64'hcbbb9d5dc1059ed8;  4'd9: h = 64'h629a292a367cd507;
        4'd10: h = 64'h9159015a3070dd17; 4'd11: h = 64'h152fecd8f70e5939;
        4'd12: h = 64'h67332667ffc00b31; 4'd13: h = 64'h8eb44a8768581511;
        4'd14: h = 64'hdb0c2e0d64f98fa7; default: h = 64'h47b5481dbefa4fa4;
      endcase
      return h;
    end
  endfunction

endpackage

[design/sha_if.sv]
`timescale 1ns / 1ps
interface sha_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic [3:0]  valid_bytes;
  logic        last_item;
  modport source (output valid, message_word, valid_bytes, last_item, input ready);
  modport sink (input valid, message_word, valid_bytes, last_item, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic        last_word;
  modport source (output valid, digest_word, last_word, input ready);
  modport sink (input valid, digest_word, last_word, output ready);
endinterface

[design/sha512_384_hasher_core.sv]
`timescale 1ns / 1ps
// SHA-512 / SHA-384 hasher. Message words arrive on the input channel, first
// byte in the top bits; the item flagged last_item carries 0..8 final bytes.
// Digest words leave on the output channel, word 0 first, last_word marking
// the final one (eight words for SHA-512, six for SHA-384).
// The sixteenth word of a block starts the compression: 80 rounds at one
// round per cycle in the single round unit, then a fold into the chaining
// value. A last item appends padding words one per cycle and may need two
// compressions; the first digest word is registered in the digest state
// that follows the last fold, and each further word is loaded into the
// output register as the previous one is transferred.
// Input ready is low while compressing, padding or sending the digest.
// The output register holds each digest word until it is transferred; a
// stalled receiver simply holds the block in the digest state.
// Reset (rst, synchronous) selects SHA-512 and loads its initial value.
// Writing variant loads the matching initial value and drops any partial
// message.
module sha512_384_hasher_core
  import sha_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [0:0] cfg_wdata,
  sha_in_if.sink  in_ch,
  sha_out_if.source out_ch
);

  typedef enum logic [2:0] {S_IDLE, S_ROUND, S_FOLD, S_PAD, S_DIGEST} state_t;

  state_t      state;
  logic        variant;
  logic        finishing;
  logic        len_done;
  logic        len_room;
  word_t       h [8];
  word_t       r [8];
  word_t       w [16];
  logic [63:0] byte_count;
  logic [3:0]  fill;
  logic [6:0]  rnd;
  logic [2:0]  dig_idx;
  logic        out_valid;
  word_t       out_word;
  logic        out_last;

  word_t       cur_w, sched, t1, t2, pad_w, in_w;
  logic [3:0]  vb;
  logic [63:0] count_next;
  logic [2:0]  dig_max;

  always_comb begin
    word_t a2, a15, s0, s1;
    a2 = w[4'(rnd - 7'd2)];
    a15 = w[4'(rnd - 7'd15)];
    s1 = {a2[18:0], a2[63:19]} ^ {a2[60:0], a2[63:61]} ^ (a2 >> 6);
    s0 = {a15[0], a15[63:1]} ^ {a15[7:0], a15[63:8]} ^ (a15 >> 7);
    sched = s1 + w[4'(rnd - 7'd7)] + s0 + w[rnd[3:0]];
    cur_w = (rnd < 7'(BlockWords)) ? w[rnd[3:0]] : sched;
    t1 = r[7] + ({r[4][13:0], r[4][63:14]} ^ {r[4][17:0], r[4][63:18]}
         ^ {r[4][40:0], r[4][63:41]}) + ((r[4] & r[5]) ^ (~r[4] & r[6]))
         + round_const(rnd) + cur_w;
    t2 = ({r[0][27:0], r[0][63:28]} ^ {r[0][33:0], r[0][63:34]}
         ^ {r[0][38:0], r[0][63:39]}) + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
  end

  // Padded form of the final input word.
  always_comb begin
    logic [63:0] keep, mark;
    vb = (in_ch.valid_bytes > 4'd8) ? 4'd8 : in_ch.valid_bytes;
    keep = ~(64'hffffffffffffffff >> {vb, 3'b000});
    mark = 64'h8000000000000000 >> {vb, 3'b000};
    in_w = (in_ch.message_word & keep) | mark;
    count_next = byte_count + (in_ch.last_item ? {60'd0, vb} : 64'd8);
  end

  // In the padding state fill says which word comes next; a full word always
  // leaves the marker for this state, held in pad_w. The length only fits in
  // the last word when the word before it was written here as zero.
  assign dig_max = variant ? 3'd5 : 3'd7;

  assign in_ch.ready = (state == S_IDLE) && !cfg_we;
  assign out_ch.valid = out_valid;
  assign out_ch.digest_word = out_word;
  assign out_ch.last_word = out_last;

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= S_IDLE;
      variant <= rst ? 1'b0 : cfg_wdata[0];
      for (int i = 0; i < 8; i++) h[i] <= init_value(rst ? 1'b0 : cfg_wdata[0], 3'(i));
      byte_count <= '0;
      fill <= '0;
      rnd <= '0;
      finishing <= 1'b0;
      len_done <= 1'b0;
      len_room <= 1'b0;
      out_valid <= 1'b0;
      dig_idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            byte_count <= count_next;
            finishing <= in_ch.last_item;
            len_done <= 1'b0;
            len_room <= 1'b0;
            if (in_ch.last_item && vb == 4'd8) begin
              w[fill] <= in_ch.message_word;
              pad_w <= PadWord;
            end else if (in_ch.last_item) begin
              w[fill] <= in_w;
              pad_w <= '0;
            end else begin
              w[fill] <= in_ch.message_word;
            end
            fill <= fill + 4'd1;
            if (fill == 4'(BlockWords - 1)) begin
              for (int i = 0; i < 8; i++) r[i] <= h[i];
              rnd <= '0;
              state <= S_ROUND;
            end else if (in_ch.last_item) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          if (fill == 4'(LenWord) && len_done == 1'b0 && len_room) begin
            w[fill] <= {byte_count[60:0], 3'b000};
            len_done <= 1'b1;
          end else begin
            w[fill] <= pad_w;
          end
          if (fill == 4'(LenWord - 1)) len_room <= (pad_w == '0);
          pad_w <= '0;
          fill <= fill + 4'd1;
          if (fill == 4'(BlockWords - 1)) begin
            for (int i = 0; i < 8; i++) r[i] <= h[i];
            rnd <= '0;
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          if (rnd >= 7'(BlockWords)) w[rnd[3:0]] <= sched;
          r[7] <= r[6]; r[6] <= r[5]; r[5] <= r[4]; r[4] <= r[3] + t1;
          r[3] <= r[2]; r[2] <= r[1]; r[1] <= r[0]; r[0] <= t1 + t2;
          rnd <= rnd + 7'd1;
          if (rnd == 7'(Rounds - 1)) state <= S_FOLD;
        end
        S_FOLD: begin
          rnd <= '0;
          for (int i = 0; i < 8; i++) h[i] <= h[i] + r[i];
          if (!finishing) begin
            state <= S_IDLE;
          end else if (len_done) begin
            state <= S_DIGEST;
            dig_idx <= '0;
            out_valid <= 1'b0;
          end else begin
            state <= S_PAD;
          end
        end
        S_DIGEST: begin
          if (!out_valid || out_ch.ready) begin
            if (out_valid && out_last) begin
              out_valid <= 1'b0;
              finishing <= 1'b0;
              byte_count <= '0;
              fill <= '0;
              for (int i = 0; i < 8; i++) h[i] <= init_value(variant, 3'(i));
              state <= S_IDLE;
            end else begin
              out_valid <= 1'b1;
              out_word <= h[dig_idx];
              out_last <= (dig_idx == dig_max);
              dig_idx <= dig_idx + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
